/* design/mcoc_pkg.sv */
// ----------------------------------------------------------------------------
// mcoc_pkg: shared types and constants of the commutation offset calibrator
// Payload structs, configuration register indexes, phase and command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcoc_pkg;

  // Input item: timestamp and measured mechanical angle
  typedef struct packed {
    logic [31:0] time_ticks;
    logic [15:0] rotor_pos;
  } sample_t;

  // Result item
  typedef struct packed {
    logic [15:0]        drive_angle;
    logic               done_res;
    logic signed [15:0] offset_angle;
    logic               reverse_dir;
  } result_t;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_EXTRA = 2'd2;

  localparam logic [6:0]  POLE_PAIRS_RESET  = 7'd1;
  localparam logic [31:0] DWELL_TICKS_RESET = 32'd1000;
  localparam logic [31:0] FIRST_EXTRA_RESET = 32'd2000;

  // Calibration phases
  localparam logic [1:0] PH_INIT  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_DIR   = 2'd2;
  localparam logic [1:0] PH_AVG   = 2'd3;

  // Controller to datapath commands
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_EVAL     = 4'd2;
  localparam logic [3:0] OP_MOD_GO   = 4'd3;
  localparam logic [3:0] OP_DIV_GO   = 4'd4;
  localparam logic [3:0] OP_ACC      = 4'd5;
  localparam logic [3:0] OP_MEAN_GO  = 4'd6;
  localparam logic [3:0] OP_MEAN_SET = 4'd7;
  localparam logic [3:0] OP_EMIT     = 4'd8;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_fire;
    logic mean_due;
    logic div_done;
    logic slot_free;
  } dp_status_t;

endpackage

/* design/mcoc_div.sv */
// ----------------------------------------------------------------------------
// mcoc_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcoc_div #(
  parameter int DW = 22,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt;
  logic [VW-1:0]   dvs;
  logic [VW:0]     trial;
  logic            fits;

  assign trial = {remainder, quotient[DW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNTW'(DW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNTW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (cnt != '0) begin
      remainder <= fits ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
      quotient  <= {quotient[DW-2:0], fits};
    end
  end

endmodule

/* design/mcoc_dp.sv */
// ----------------------------------------------------------------------------
// mcoc_dp: calibrator datapath
// Configuration registers written over cfg; calibration state, angle math,
// the shared divider and result register, stepped by controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcoc_dp #(
  parameter int MAX_POLE_PAIRS = 64,
  parameter int ANGLE_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [mcoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  mcoc_pkg::sample_t               sample_data,
  input  mcoc_pkg::dp_cmd_t               cmd,
  output mcoc_pkg::dp_status_t            status,
  output logic                            result_valid,
  input  logic                            result_ready,
  output mcoc_pkg::result_t               result_data
);

  import mcoc_pkg::*;

  localparam int AB   = ANGLE_BITS;
  localparam int PPW  = $clog2(MAX_POLE_PAIRS + 1);
  localparam int FW   = AB + PPW;
  localparam int CW   = $clog2(6 * MAX_POLE_PAIRS + 1);
  localparam int SUMW = AB + 3;
  localparam int DW   = (FW > AB + 2) ? FW : AB + 2;

  localparam longint unsigned U64 = 64'd1 << ANGLE_BITS;
  localparam logic [AB-1:0] DEG30   = AB'((U64 + 64'd6) / 64'd12);
  localparam logic [AB-1:0] DEG60   = AB'((U64 + 64'd3) / 64'd6);
  localparam logic [AB-1:0] DEG330  = AB'((U64 * 64'd11 + 64'd6) / 64'd12);
  localparam logic [FW-1:0] QUARTER = FW'(U64 / 64'd4);

  localparam logic [SUMW-1:0] UNITS       = {3'b001, {AB{1'b0}}};
  localparam logic [SUMW-1:0] THREE_UNITS = {3'b011, {AB{1'b0}}};
  localparam logic [SUMW-1:0] FIVE_UNITS  = {3'b101, {AB{1'b0}}};
  localparam logic [SUMW-1:0] SIX_UNITS   = {3'b110, {AB{1'b0}}};

  // configuration
  logic [6:0]  pole_pairs;
  logic [31:0] dwell_ticks;
  logic [31:0] first_extra_ticks;

  // calibration state
  logic [1:0]           phase;
  logic [31:0]          last_time;
  logic [AB-1:0]        cmd_acc;
  logic [FW-1:0]        fit_acc;
  logic [AB-1:0]        first_reading;
  logic                 dir_rev;
  logic                 full_wrap;
  logic [CW-1:0]        sample_count;
  logic [SUMW-1:0]      offset_sum;
  logic signed [AB:0]   mean_offset;

  // per-item registers
  logic [31:0]   now_r;
  logic [AB-1:0] mech_r;
  logic [AB-1:0] drive_before;
  logic [FW-1:0] frac;
  logic          samp_dir;
  logic          done_flag;

  // divider
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [CW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [CW-1:0] div_rem;

  logic [PPW-1:0] pp_eff;
  logic [FW-1:0]  span;
  logic [CW-1:0]  six_pp;
  logic [31:0]    el;
  logic           first_fire;
  logic           samp_fire;

  logic [AB:0]    delta;
  logic           delta_pos;
  logic [FW-1:0]  dprod;
  logic           rev_new;
  logic [FW:0]    t_dir;
  logic [FW-1:0]  fit_dir;

  logic [FW-1:0]   frac_now;
  logic [AB-1:0]   q_ang;
  logic [AB-1:0]   angle_off;
  logic            wrap_new;
  logic            off_neg;
  logic [SUMW-1:0] sp;
  logic [SUMW-1:0] sum_next;
  logic [FW:0]     t_step;
  logic [FW-1:0]   fit_step;

  logic               mean_neg;
  logic [SUMW-1:0]    mean_mag;
  logic signed [AB:0] q_mean;
  logic signed [AB:0] mean_new;

  // clamp pole pairs to 1..MAX_POLE_PAIRS
  always_comb begin
    if (pole_pairs == '0) begin
      pp_eff = PPW'(1);
    end else if (32'(pole_pairs) > 32'(MAX_POLE_PAIRS)) begin
      pp_eff = PPW'(MAX_POLE_PAIRS);
    end else begin
      pp_eff = PPW'(pole_pairs);
    end
  end

  assign span   = FW'(pp_eff) << AB;
  assign six_pp = CW'(pp_eff) * CW'(6);

  assign el         = now_r - last_time;
  assign first_fire = ({1'b0, el} > ({1'b0, dwell_ticks} + {1'b0, first_extra_ticks}));
  assign samp_fire  = (el > dwell_ticks);

  // direction: forward when the second reading leads by under a quarter
  // electrical turn
  assign delta     = {1'b0, mech_r} - {1'b0, first_reading};
  assign delta_pos = !delta[AB] && (delta[AB-1:0] != '0);
  assign dprod     = FW'(delta[AB-1:0]) * FW'(pp_eff);
  assign rev_new   = !(delta_pos && (dprod < QUARTER));

  always_comb begin
    if (rev_new) begin
      t_dir = {1'b0, span} + (FW+1)'(cmd_acc) - (FW+1)'(QUARTER);
    end else begin
      t_dir = (FW+1)'(cmd_acc) + (FW+1)'(QUARTER);
    end
    fit_dir = (t_dir >= {1'b0, span}) ? FW'(t_dir - {1'b0, span}) : FW'(t_dir);
  end

  // fit angle reduced to one electrical span; low bits pass through
  assign frac_now = {div_rem[PPW-1:0], fit_acc[AB-1:0]};

  // offset of this sample and its running sum mod six turns
  assign q_ang     = div_quo[AB-1:0];
  assign angle_off = dir_rev ? ('0 - q_ang - mech_r) : (q_ang - mech_r);
  assign wrap_new  = samp_dir ? ((angle_off > DEG30) && (angle_off < DEG330)) : full_wrap;
  assign off_neg   = !wrap_new && angle_off[AB-1];
  assign sp        = offset_sum + SUMW'(angle_off);

  always_comb begin
    if (off_neg) begin
      sum_next = (sp >= UNITS) ? sp - UNITS : sp + FIVE_UNITS;
    end else begin
      sum_next = (sp >= SIX_UNITS) ? sp - SIX_UNITS : sp;
    end
    t_step   = (FW+1)'(frac) + (FW+1)'(DEG60);
    fit_step = (t_step >= {1'b0, span}) ? FW'(t_step - {1'b0, span}) : FW'(t_step);
  end

  // fold the sum into (-3, 3] turns and round the mean half away from zero
  assign mean_neg = (offset_sum > THREE_UNITS);
  assign mean_mag = mean_neg ? SIX_UNITS - offset_sum : offset_sum;
  assign q_mean   = signed'({1'b0, div_quo[AB-1:0]});
  assign mean_new = mean_neg ? -q_mean : q_mean;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = CW'(pp_eff);
    case (cmd.op)
      OP_MOD_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(fit_acc[FW-1:AB]);
      end
      OP_DIV_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(frac_now) + DW'(pp_eff >> 1);
      end
      OP_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(mean_mag) + DW'(six_pp >> 1);
        div_divisor  = six_pp;
      end
      default: ;
    endcase
  end

  mcoc_div #(
    .DW (DW),
    .VW (CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    status.sample_fire = ((phase == PH_DIR) || (phase == PH_AVG)) && samp_fire;
    status.mean_due    = (sample_count >= six_pp);
    status.div_done    = div_done;
    status.slot_free   = !result_valid || result_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs        <= POLE_PAIRS_RESET;
      dwell_ticks       <= DWELL_TICKS_RESET;
      first_extra_ticks <= FIRST_EXTRA_RESET;
      phase             <= PH_INIT;
      last_time         <= '0;
      cmd_acc           <= '0;
      fit_acc           <= '0;
      first_reading     <= '0;
      dir_rev           <= 1'b0;
      full_wrap         <= 1'b0;
      sample_count      <= '0;
      offset_sum        <= '0;
      mean_offset       <= '0;
      samp_dir          <= 1'b0;
      done_flag         <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_POLE_PAIRS:  pole_pairs        <= cfg_data[6:0];
          CFG_DWELL_TICKS: dwell_ticks       <= cfg_data;
          CFG_FIRST_EXTRA: first_extra_ticks <= cfg_data;
          default: ;
        endcase
      end

      case (cmd.op)
        OP_LOAD: begin
          done_flag <= 1'b0;
        end
        OP_EVAL: begin
          samp_dir <= (phase == PH_DIR) && samp_fire;
          case (phase)
            PH_INIT: begin
              last_time    <= now_r;
              cmd_acc      <= DEG30;
              sample_count <= '0;
              offset_sum   <= '0;
              phase        <= PH_FIRST;
            end
            PH_FIRST: begin
              if (first_fire) begin
                first_reading <= mech_r;
                cmd_acc       <= cmd_acc + DEG60;
                last_time     <= now_r;
                phase         <= PH_DIR;
              end
            end
            PH_DIR: begin
              if (samp_fire) begin
                dir_rev <= rev_new;
                fit_acc <= fit_dir;
                phase   <= PH_AVG;
              end
            end
            default: ;
          endcase
        end
        OP_ACC: begin
          full_wrap    <= wrap_new;
          offset_sum   <= sum_next;
          cmd_acc      <= cmd_acc + DEG60;
          fit_acc      <= fit_step;
          last_time    <= now_r;
          sample_count <= sample_count + 1'b1;
        end
        OP_MEAN_SET: begin
          mean_offset <= mean_new;
          phase       <= PH_INIT;
          done_flag   <= 1'b1;
        end
        default: ;
      endcase

      if (cmd.op == OP_EMIT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      now_r        <= sample_data.time_ticks;
      mech_r       <= AB'(sample_data.rotor_pos);
      drive_before <= cmd_acc;
    end
    if (cmd.op == OP_DIV_GO) begin
      frac <= frac_now;
    end
    if (cmd.op == OP_EMIT) begin
      // hold the previous command angle on the finishing item
      result_data.drive_angle  <= 16'(32'(done_flag ? drive_before : cmd_acc));
      result_data.done_res     <= done_flag;
      result_data.offset_angle <= 16'(32'(mean_offset));
      result_data.reverse_dir  <= dir_rev;
    end
  end

endmodule

/* design/mcoc_ctrl.sv */
// ----------------------------------------------------------------------------
// mcoc_ctrl: calibrator sequencer
// Steps one item through evaluate, reduce, divide, accumulate, mean and emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcoc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  mcoc_pkg::dp_status_t status,
  output mcoc_pkg::dp_cmd_t    cmd
);

  import mcoc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EVAL      = 4'd1;
  localparam logic [3:0] S_MOD_GO    = 4'd2;
  localparam logic [3:0] S_MOD_WAIT  = 4'd3;
  localparam logic [3:0] S_DIV_GO    = 4'd4;
  localparam logic [3:0] S_DIV_WAIT  = 4'd5;
  localparam logic [3:0] S_ACC       = 4'd6;
  localparam logic [3:0] S_CHECK     = 4'd7;
  localparam logic [3:0] S_MEAN_GO   = 4'd8;
  localparam logic [3:0] S_MEAN_WAIT = 4'd9;
  localparam logic [3:0] S_MEAN_SET  = 4'd10;
  localparam logic [3:0] S_FINISH    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign sample_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op     = OP_EVAL;
        state_next = status.sample_fire ? S_MOD_GO : S_CHECK;
      end
      S_MOD_GO: begin
        cmd.op     = OP_MOD_GO;
        state_next = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (status.div_done) begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.op     = OP_DIV_GO;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.mean_due ? S_MEAN_GO : S_FINISH;
      end
      S_MEAN_GO: begin
        cmd.op     = OP_MEAN_GO;
        state_next = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (status.div_done) begin
          state_next = S_MEAN_SET;
        end
      end
      S_MEAN_SET: begin
        cmd.op     = OP_MEAN_SET;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (status.slot_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/motor_commutation_offset_calibrator.sv */
// ----------------------------------------------------------------------------
// motor_commutation_offset_calibrator: commutation offset calibration
// Steps the electrical drive angle by 60 degrees per dwell, measures the
// rotor angle, finds the rotation direction and averages 6*pole_pairs
// offsets into a mean commutation offset.
//
// Channels: sample (time_ticks, rotor_pos) in, result (drive_angle,
// done_res, offset_angle, reverse_dir) out, one result per sample, both
// valid/ready. cfg writes pole_pairs (0), dwell_ticks (1), first_extra_ticks
// (2); cfg_ready is always high, other indexes are ignored.
// One sample at a time: a new sample is accepted only after the result of
// the previous one has been emitted. The bit-serial divider is shared by
// the angle and mean divisions.
// The output register frees the core: a result waiting on a stalled
// receiver blocks only the emit of the next one, not its acceptance.
// Reset loads the register defaults and restarts calibration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_commutation_offset_calibrator #(
  parameter int MAX_POLE_PAIRS = 64,
  parameter int ANGLE_BITS     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  mcoc_pkg::sample_t              sample_data,
  output logic                           result_valid,
  input  logic                           result_ready,
  output mcoc_pkg::result_t              result_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  import mcoc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mcoc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  mcoc_dp #(
    .MAX_POLE_PAIRS (MAX_POLE_PAIRS),
    .ANGLE_BITS     (ANGLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_data  (sample_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

/* design/mcoc_checker.sv */
// ----------------------------------------------------------------------------
// mcoc_checker: port-level checks of the calibrator
// Watches the sample and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcoc_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input mcoc_pkg::result_t result_data,
  input logic              result_valid,
  input logic              result_ready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // one sample in flight: ready drops after a transfer
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while busy");

  // no result can appear in the cycle right after a sample transfer
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !$rose(result_valid))
    else $error("result too early");

  // reset empties the output and opens the input
  assert property (@(posedge clk)
    $fell(rst) |-> !result_valid && sample_ready)
    else $error("bad state after reset");

endmodule

bind motor_commutation_offset_calibrator mcoc_port_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_data  (result_data),
  .result_valid (result_valid),
  .result_ready (result_ready)
);

/* tb/sv/mcoc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcoc_checker: result checker for the commutation offset calibrator
// Watches the sample, result and register write transfers, runs its own
// calibration model on every accepted sample and compares each result,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------

module mcoc_checker #(
  parameter int MAX_POLE_PAIRS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  input  logic                           sample_ready,
  input  mcoc_pkg::sample_t              sample_data,
  input  logic                           result_valid,
  input  logic                           result_ready,
  input  mcoc_pkg::result_t              result_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mcoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int unsigned                    pending,
  output int unsigned                    errors
);
  import mcoc_pkg::*;

  localparam logic [63:0] UNITS        = 64'd65536;
  localparam logic [63:0] HALF_TURN    = UNITS / 2;
  localparam logic [63:0] QUARTER_TURN = UNITS / 4;
  localparam logic [63:0] DEG30        = (UNITS + 6) / 12;
  localparam logic [63:0] DEG60        = (UNITS + 3) / 6;
  localparam logic [63:0] DEG330       = (UNITS * 11 + 6) / 12;

  // register copies
  logic [6:0]  cfg_pairs;
  logic [31:0] cfg_dwell;
  logic [31:0] cfg_extra;

  // calibration state
  logic [1:0]         cal_phase;
  logic [31:0]        t_last;
  logic [15:0]        drive_acc;
  logic [23:0]        fit_acc;
  logic [15:0]        ref_mech;
  logic               rev;
  logic               wrap_full;
  logic [8:0]         n_samples;
  logic signed [25:0] offset_acc;
  logic signed [16:0] mean_off;

  result_t want_q[$];
  result_t want;

  task automatic report_error(input string field, input longint got, input longint exp_val);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, exp_val);
    errors++;
  endtask

  // expected electrical angle over pole pairs minus the measured one, one turn
  function automatic logic [15:0] offset_of(input logic [6:0] pp, input logic [15:0] mech);
    logic [63:0] span;
    logic [63:0] q;
    span = UNITS * pp;
    q = ((64'(fit_acc) % span) + 64'(pp / 2)) / 64'(pp);
    return rev ? 16'(-q - mech) : 16'(q - mech);
  endfunction

  function automatic result_t step_calibration(input sample_t s);
    logic [6:0]  pp;
    logic [63:0] span;
    logic [31:0] el;
    logic [15:0] drive_prev;
    logic [15:0] o;
    logic [1:0]  start;
    logic        done;
    logic        fire;
    longint      delta;
    longint      v;
    longint      six;
    longint      m;
    longint      mag;
    longint      qd;
    result_t     r;
    pp = (cfg_pairs == 0) ? 7'd1 :
         (cfg_pairs > MAX_POLE_PAIRS) ? 7'(MAX_POLE_PAIRS) : cfg_pairs;
    span = UNITS * pp;
    drive_prev = drive_acc;
    start = cal_phase;
    done = 1'b0;

    if (start == PH_INIT) begin
      t_last = s.time_ticks;
      drive_acc = 16'(DEG30);
      n_samples = '0;
      offset_acc = '0;
      cal_phase = PH_FIRST;
    end
    el = s.time_ticks - t_last;
    if (start == PH_INIT || start == PH_FIRST) begin
      if (33'(el) > 33'(cfg_dwell) + 33'(cfg_extra)) begin
        ref_mech = s.rotor_pos;
        drive_acc = drive_acc + 16'(DEG60);
        t_last = s.time_ticks;
        cal_phase = PH_DIR;
      end
    end else begin
      fire = el > cfg_dwell;
      // direction step also takes the first offset sample
      if (start == PH_DIR && fire) begin
        delta = longint'(s.rotor_pos) - longint'(ref_mech);
        rev = !(delta > 0 && delta * 4 * longint'(pp) < longint'(UNITS));
        fit_acc = 24'((64'(drive_acc) + (rev ? span - QUARTER_TURN : QUARTER_TURN)) % span);
        o = offset_of(pp, s.rotor_pos);
        wrap_full = (64'(o) > DEG30) && (64'(o) < DEG330);
        cal_phase = PH_AVG;
      end
      if (fire) begin
        o = offset_of(pp, s.rotor_pos);
        v = longint'(o);
        if (!wrap_full && 64'(o) >= HALF_TURN) v -= longint'(UNITS);
        offset_acc = 26'(longint'(offset_acc) + v);
        drive_acc = drive_acc + 16'(DEG60);
        fit_acc = 24'(((64'(fit_acc) % span) + DEG60) % span);
        t_last = s.time_ticks;
        n_samples = n_samples + 9'd1;
      end
      if (int'(n_samples) >= 6 * int'(pp)) begin
        // fold into (-3, 3] turns, then round the mean half away from zero
        six = 6 * longint'(UNITS);
        m = longint'(offset_acc) % six;
        if (m < 0) m += six;
        if (m > 3 * longint'(UNITS)) m -= six;
        mag = (m < 0) ? -m : m;
        qd = (mag + 3 * longint'(pp)) / (6 * longint'(pp));
        mean_off = 17'((m < 0) ? -qd : qd);
        cal_phase = PH_INIT;
        done = 1'b1;
      end
    end

    r.drive_angle = done ? drive_prev : drive_acc;
    r.done_res = done;
    r.offset_angle = mean_off[15:0];
    r.reverse_dir = rev;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_pairs  = POLE_PAIRS_RESET;
      cfg_dwell  = DWELL_TICKS_RESET;
      cfg_extra  = FIRST_EXTRA_RESET;
      cal_phase  = PH_INIT;
      t_last     = '0;
      drive_acc  = '0;
      fit_acc    = '0;
      ref_mech   = '0;
      rev        = 1'b0;
      wrap_full  = 1'b0;
      n_samples  = '0;
      offset_acc = '0;
      mean_off   = '0;
      want_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLE_PAIRS:  cfg_pairs = cfg_data[6:0];
          CFG_DWELL_TICKS: cfg_dwell = cfg_data;
          CFG_FIRST_EXTRA: cfg_extra = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (want_q.size() == 0) begin
          report_error("unexpected result, drive_angle", result_data.drive_angle, 0);
        end else begin
          want = want_q.pop_front();
          if (result_data.drive_angle !== want.drive_angle)
            report_error("drive_angle", result_data.drive_angle, want.drive_angle);
          if (result_data.done_res !== want.done_res)
            report_error("done_res", result_data.done_res, want.done_res);
          if (result_data.offset_angle !== want.offset_angle)
            report_error("offset_angle", longint'(result_data.offset_angle),
                         longint'(want.offset_angle));
          if (result_data.reverse_dir !== want.reverse_dir)
            report_error("reverse_dir", result_data.reverse_dir, want.reverse_dir);
        end
      end
      if (sample_valid && sample_ready) want_q.push_back(step_calibration(sample_data));
      pending <= want_q.size();
    end
  end

endmodule

/* tb/sv/tb_motor_commutation_offset_calibrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_commutation_offset_calibrator: calibrator testbench
// Drives directed calibration runs (timestamp wrap, zero dwell, an endless
// first wait, clamped and dropped pole counts, a mean of half a turn), then
// random register settings with rotor-like angle sequences under varying
// sender and receiver stalls. Checking is done by mcoc_checker.
// ----------------------------------------------------------------------------

module tb_motor_commutation_offset_calibrator;
  import mcoc_pkg::*;

  localparam int RAND_ITEMS  = 1150;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  sample_t              sample_data = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int unsigned pending;
  int unsigned errors;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          rnd_sent = 0;
  int          quiet_cycles = 0;
  logic [31:0] now_ticks;
  logic [31:0] cur_dwell;
  logic [31:0] cur_extra;

  motor_commutation_offset_calibrator i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mcoc_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .errors       (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // end the run if no transfer happens on any channel for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold valid across back-to-back samples; drop it only while idling
  task automatic send_sample(input logic [31:0] t, input logic [15:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data <= '{time_ticks: t, rotor_pos: angle};
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_config(input logic [31:0] pairs_word, input logic [31:0] dwell,
                             input logic [31:0] extra);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [31:0]          val [4];
    drain_results();
    idx = '{CFG_POLE_PAIRS, CFG_DWELL_TICKS, CFG_FIRST_EXTRA, CFG_SPARE};
    val = '{pairs_word, dwell, extra, $urandom};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_dwell = dwell;
    cur_extra = extra;
  endtask

  // rotor follows the 60 degree electrical steps, with jitter and stray readings
  task automatic run_random_phase(input int pairs, input int n_items);
    int          eff;
    int          step;
    int          dirn;
    int          kind;
    logic [15:0] rotor;
    logic [15:0] angle;
    logic [31:0] dwell;
    logic [31:0] extra;
    logic [63:0] dt;
    eff = (pairs == 0) ? 1 : (pairs > 64) ? 64 : pairs;
    step = 10923 / eff;
    dirn = $urandom_range(1) ? 1 : -1;
    rotor = 16'($urandom);
    kind = $urandom_range(99);
    if (kind < 60) dwell = $urandom_range(40);
    else if (kind < 85) dwell = $urandom_range(32'h000F_FFFF);
    else dwell = $urandom_range(32'hFFFF_0000, 32'h8000_0000);
    kind = $urandom_range(99);
    if (kind < 50) extra = $urandom_range(64);
    else if (kind < 80) extra = $urandom_range(32'hFFFF_FE00 - dwell);
    else extra = '0;
    load_config(($urandom & 32'hFFFF_FF80) | 32'(pairs), dwell, extra);

    for (int n = 0; n < n_items; n++) begin
      if (rnd_sent < RAND_ITEMS / 3) begin
        send_idle_pct = 6;
        recv_idle_pct <= 85;
      end else if (rnd_sent < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 85;
        recv_idle_pct <= 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      kind = $urandom_range(99);
      if (kind < 12) begin
        dt = 64'($urandom_range(cur_dwell));
        angle = rotor + 16'($urandom_range(32)) - 16'd16;
      end else begin
        dt = 64'(cur_dwell) + 64'(cur_extra) + 64'd1 + 64'($urandom_range(255));
        rotor = rotor + 16'(dirn * step) + 16'($urandom_range(96)) - 16'd48;
        angle = rotor;
      end
      if (kind >= 95) angle = 16'($urandom);
      now_ticks = now_ticks + dt[31:0];
      send_sample(now_ticks, angle);
      rnd_sent++;
    end
  endtask

  initial begin
    int pairs;
    int kind;
    int eff;
    int n_items;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero dwell, timestamp wrap, reverse run with every offset at half a turn
    load_config(32'd1, 32'd0, 32'd0);
    send_sample(32'hFFFF_FFFE, 16'h1234);
    send_sample(32'hFFFF_FFFF, 16'h0000);
    send_sample(32'hFFFF_FFFF, 16'hABCD);
    send_sample(32'h0000_0000, 16'd32768);
    send_sample(32'd1, 16'd21845);
    send_sample(32'd2, 16'd10922);
    send_sample(32'd3, 16'hFFFF);
    send_sample(32'd4, 16'd54612);
    send_sample(32'd5, 16'd43689);

    // first wait that never ends: threshold at or above 2^32 - 1, which no 32-bit elapsed time exceeds
    load_config(32'd0, 32'hFFFF_FFFF, 32'd1);
    send_sample(32'd100, 16'h8000);
    send_sample(32'h8000_0064, 16'h7FFF);
    load_config(32'd0, 32'd0, 32'hFFFF_FFFF);
    send_sample(32'd99, 16'hFFFF);

    // clamp above the maximum, then drop the pole count while averaging
    load_config(32'd127, 32'd10, 32'd0);
    send_sample(32'd200, 16'h0100);
    send_sample(32'd300, 16'h0110);
    send_sample(32'd400, 16'($urandom));
    send_sample(32'd500, 16'($urandom));
    send_sample(32'd600, 16'($urandom));
    send_sample(32'd700, 16'($urandom));
    send_sample(32'd800, 16'($urandom));
    load_config(32'd0, 32'd10, 32'd0);
    send_sample(32'd805, 16'h5555);

    now_ticks = $urandom;
    for (int phase_no = 0; rnd_sent < RAND_ITEMS; phase_no++) begin
      if (phase_no == 1) begin
        run_random_phase(64, 440);
      end else begin
        kind = $urandom_range(99);
        if (kind < 75) pairs = $urandom_range(4, 1);
        else if (kind < 92) pairs = $urandom_range(12, 5);
        else if (kind < 96) pairs = 0;
        else pairs = $urandom_range(127, 65);
        eff = (pairs == 0) ? 1 : pairs;
        // clamped counts get a partial run only
        if (eff > 12) n_items = 60;
        else n_items = $urandom_range(14 * eff + 10, 6 * eff + 4);
        run_random_phase(pairs, n_items);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
